// File: src/qas_pkg.sv
// ----------------------------------------------------------------------------
// qas_pkg
// Types, byte codes and helper functions shared by the argument splitter.
// ----------------------------------------------------------------------------
package qas_pkg;

  localparam logic [7:0] CHAR_NUL       = 8'h00;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
  localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
  localparam logic [7:0] CHAR_BQUOTE    = 8'h60;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_TAB       = 8'h09;
  localparam logic [7:0] CHAR_CR        = 8'h0D;

  localparam logic [7:0] MAX_ARGS_RESET = 8'd64;

  // result kinds
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_ARG_END = 2'd1;
  localparam logic [1:0] KIND_EOL     = 2'd2;

  typedef enum logic [1:0] {
    QUOTE_NONE   = 2'd0,
    QUOTE_SINGLE = 2'd1,
    QUOTE_DOUBLE = 2'd2,
    QUOTE_BACK   = 2'd3
  } quote_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [7:0] arg_index;
    logic       last;
  } result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  function automatic quote_e quote_code(input logic [7:0] c);
    quote_e q;
    case (c)
      CHAR_SQUOTE: q = QUOTE_SINGLE;
      CHAR_DQUOTE: q = QUOTE_DOUBLE;
      CHAR_BQUOTE: q = QUOTE_BACK;
      default:     q = QUOTE_NONE;
    endcase
    return q;
  endfunction

endpackage

// File: src/qas_char_if.sv
// ----------------------------------------------------------------------------
// qas_char_if
// Byte stream channel into the splitter: valid, ready and one byte.
// ----------------------------------------------------------------------------
interface qas_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

// File: src/qas_result_if.sv
// ----------------------------------------------------------------------------
// qas_result_if
// Result channel out of the splitter: valid, ready and one tagged result.
// ----------------------------------------------------------------------------
interface qas_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value;
  logic [7:0] arg_index;
  logic       last;

  modport source (output valid, output kind, output value, output arg_index,
                  output last, input ready);
  modport sink   (input valid, input kind, input value, input arg_index,
                  input last, output ready);
endinterface

// File: src/qas_cfg_if.sv
// ----------------------------------------------------------------------------
// qas_cfg_if
// Configuration write channel carrying the argument limit.
// ----------------------------------------------------------------------------
interface qas_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] max_args;

  modport source (output valid, output max_args, input ready);
  modport sink   (input valid, input max_args, output ready);
endinterface

// File: src/quoted_argument_splitter_top.sv
// ----------------------------------------------------------------------------
// quoted_argument_splitter_top
// Splits a zero-terminated byte line into shell-style arguments.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the result queue has room. A byte is
// registered, decoded against the line state and its results (none, one or
// two) are written to a two-entry result queue. The output delivers one result
// per cycle while the receiver is ready, which sets the rate; a line end inside
// an argument yields both an end of argument and an end of line. The
// configuration channel is always ready and writes max_args.
module quoted_argument_splitter_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  qas_cfg_if.sink           cfg_i,
  qas_char_if.sink          char_i,
  qas_result_if.source      result_o
);

  // configuration
  logic [7:0] max_args_q;

  // input register
  logic       in_valid_q;
  logic [7:0] char_q;

  // line state
  logic                inside_q, inside_d;
  logic                esc_q, esc_d;
  qas_pkg::quote_e     quote_q, quote_d;
  logic [7:0]          count_q, count_d;
  logic                limit_q, limit_d;

  // result queue, slot 0 is the head
  qas_pkg::result_t    slot0_q, slot0_d, slot1_q, slot1_d;
  logic [1:0]          fill_q, fill_d;

  // decode of the registered byte
  qas_pkg::result_t    res0, res1;
  logic [1:0]          n_res;
  logic                sp;
  logic                starts;
  logic [7:0]          cnt_new;
  logic [7:0]          idx;
  qas_pkg::quote_e     q;

  logic       pop;
  logic [1:0] kept;
  logic       consume;
  logic       accept;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_args_q <= qas_pkg::MAX_ARGS_RESET;
    end else if (cfg_i.valid) begin
      max_args_q <= cfg_i.max_args;
    end
  end

  always_comb begin
    res0      = '0;
    res1      = '0;
    n_res     = 2'd0;
    inside_d  = inside_q;
    esc_d     = esc_q;
    quote_d   = quote_q;
    count_d   = count_q;
    limit_d   = limit_q;
    sp        = qas_pkg::is_space(char_q);
    q         = qas_pkg::quote_code(char_q);
    starts    = !inside_q;
    cnt_new   = starts ? 8'(count_q + 8'd1) : count_q;
    idx       = 8'(cnt_new - 8'd1);

    if (char_q == qas_pkg::CHAR_NUL) begin
      if (inside_q) begin
        res0  = '{kind: qas_pkg::KIND_ARG_END, value: 8'd0,
                  arg_index: 8'(count_q - 8'd1), last: 1'b0};
        res1  = '{kind: qas_pkg::KIND_EOL, value: 8'd0, arg_index: count_q, last: 1'b1};
        n_res = 2'd2;
      end else begin
        res0  = '{kind: qas_pkg::KIND_EOL, value: 8'd0, arg_index: count_q, last: 1'b1};
        n_res = 2'd1;
      end
      inside_d = 1'b0;
      esc_d    = 1'b0;
      quote_d  = qas_pkg::QUOTE_NONE;
      count_d  = 8'd0;
      limit_d  = 1'b0;
    end else if (!limit_q && !(starts && (sp || count_q >= max_args_q))) begin
      inside_d = 1'b1;
      count_d  = cnt_new;
      if (esc_q) begin
        esc_d = 1'b0;
        res0  = '{kind: qas_pkg::KIND_BYTE, value: char_q, arg_index: idx, last: 1'b1};
        n_res = 2'd1;
      end else if (char_q == qas_pkg::CHAR_BACKSLASH) begin
        esc_d = 1'b1;
      end else if (quote_q != qas_pkg::QUOTE_NONE && q == quote_q) begin
        quote_d = qas_pkg::QUOTE_NONE;
      end else if (q != qas_pkg::QUOTE_NONE) begin
        quote_d = q;
      end else if (quote_q != qas_pkg::QUOTE_NONE) begin
        res0  = '{kind: qas_pkg::KIND_BYTE, value: char_q, arg_index: idx, last: 1'b1};
        n_res = 2'd1;
      end else if (sp) begin
        inside_d = 1'b0;
        res0     = '{kind: qas_pkg::KIND_ARG_END, value: 8'd0, arg_index: idx, last: 1'b1};
        n_res    = 2'd1;
        if (cnt_new >= max_args_q) begin
          limit_d = 1'b1;
        end
      end else begin
        res0  = '{kind: qas_pkg::KIND_BYTE, value: char_q, arg_index: idx, last: 1'b1};
        n_res = 2'd1;
      end
    end
  end

  // queue bookkeeping: entries kept after this cycle's output transfer
  assign pop     = (fill_q != 2'd0) && result_o.ready;
  assign kept    = fill_q - {1'b0, pop};
  assign consume = in_valid_q && ({1'b0, n_res} + {1'b0, kept} <= 3'd2);
  assign accept  = char_i.valid && char_i.ready;

  assign char_i.ready = !in_valid_q || consume;

  always_comb begin
    if (kept != 2'd0) begin
      slot0_d = pop ? slot1_q : slot0_q;
    end else begin
      slot0_d = res0;
    end
    case (kept)
      2'd2:    slot1_d = slot1_q;
      2'd1:    slot1_d = res0;
      default: slot1_d = res1;
    endcase
    fill_d = consume ? 2'(kept + n_res) : kept;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      fill_q     <= 2'd0;
      inside_q   <= 1'b0;
      esc_q      <= 1'b0;
      quote_q    <= qas_pkg::QUOTE_NONE;
      count_q    <= 8'd0;
      limit_q    <= 1'b0;
    end else begin
      in_valid_q <= accept || (in_valid_q && !consume);
      fill_q     <= fill_d;
      if (consume) begin
        inside_q <= inside_d;
        esc_q    <= esc_d;
        quote_q  <= quote_d;
        count_q  <= count_d;
        limit_q  <= limit_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= char_i.char_code;
    end
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign result_o.valid     = (fill_q != 2'd0);
  assign result_o.kind      = slot0_q.kind;
  assign result_o.value     = slot0_q.value;
  assign result_o.arg_index = slot0_q.arg_index;
  assign result_o.last      = slot0_q.last;

endmodule

// File: src/qas_checker.sv
// ----------------------------------------------------------------------------
// qas_checker
// Port-level checks on the splitter's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module qas_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       res_valid_i,
  input  logic       res_ready_i,
  input  logic [1:0] res_kind_i,
  input  logic [7:0] res_value_i,
  input  logic [7:0] res_arg_index_i,
  input  logic       res_last_i
);

  // a waiting result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=>
      res_valid_i && $stable(res_kind_i) && $stable(res_value_i)
      && $stable(res_arg_index_i) && $stable(res_last_i))
    else $error("result payload changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (res_kind_i == qas_pkg::KIND_BYTE)
      || (res_kind_i == qas_pkg::KIND_ARG_END) || (res_kind_i == qas_pkg::KIND_EOL))
    else $error("illegal result kind");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_kind_i != qas_pkg::KIND_BYTE) |-> res_value_i == 8'd0)
    else $error("marker result carries a nonzero value");

  // the line end is always the final result of its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_kind_i == qas_pkg::KIND_EOL) |-> res_last_i)
    else $error("end of line without last");

  // an end of argument not marked last must be followed by the line end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_ready_i && (res_kind_i == qas_pkg::KIND_ARG_END) && !res_last_i
      |=> res_valid_i && (res_kind_i == qas_pkg::KIND_EOL)
          && (res_arg_index_i == 8'($past(res_arg_index_i) + 8'd1)))
    else $error("line end did not follow its closing argument");

endmodule

bind quoted_argument_splitter_top qas_checker u_qas_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .res_valid_i     (result_o.valid),
  .res_ready_i     (result_o.ready),
  .res_kind_i      (result_o.kind),
  .res_value_i     (result_o.value),
  .res_arg_index_i (result_o.arg_index),
  .res_last_i      (result_o.last)
);

// File: verif/tb_quoted_argument_splitter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quoted_argument_splitter_top
// Feeds byte lines into the argument splitter and mirrors the line state to
// predict each argument byte, argument end and line end. Every result on the
// output channel is checked against the oldest prediction. Both channels idle
// and stall at random, and the argument limit changes between lines and once mid-line.
// ----------------------------------------------------------------------------
module tb_quoted_argument_splitter_top;

  localparam int WATCHDOG_LIMIT = 500;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RANDOM_ITEMS   = 600;

  typedef logic [7:0] byte_q_t[$];

  logic clk;
  logic rst_n;

  qas_cfg_if    cfg_bus ();
  qas_char_if   char_bus ();
  qas_result_if res_bus ();

  quoted_argument_splitter_top dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .cfg_i    (cfg_bus),
    .char_i   (char_bus),
    .result_o (res_bus)
  );

  // mirror of the line state
  logic [7:0]      arg_limit;
  logic            in_word;
  logic            escape_armed;
  logic            cap_hit;
  qas_pkg::quote_e quote_open;
  logic [7:0]      word_count;

  qas_pkg::result_t split_results_q[$];
  int               fail_count;
  int               bytes_sent;
  bit               no_gaps;
  int               res_stall;

  always #2 clk = ~clk;

  function automatic bit is_blank(input logic [7:0] c);
    case (c)
      8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, qas_pkg::CHAR_SPACE: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic qas_pkg::quote_e quote_of(input logic [7:0] c);
    if (c == qas_pkg::CHAR_SQUOTE) return qas_pkg::QUOTE_SINGLE;
    if (c == qas_pkg::CHAR_DQUOTE) return qas_pkg::QUOTE_DOUBLE;
    if (c == qas_pkg::CHAR_BQUOTE) return qas_pkg::QUOTE_BACK;
    return qas_pkg::QUOTE_NONE;
  endfunction

  function automatic qas_pkg::result_t make_result(input logic [1:0] kind,
                                                   input logic [7:0] value,
                                                   input logic [7:0] idx);
    qas_pkg::result_t r;
    r.kind      = kind;
    r.value     = value;
    r.arg_index = idx;
    r.last      = 1'b0;
    return r;
  endfunction

  function void clear_line_state();
    in_word      = 1'b0;
    escape_armed = 1'b0;
    cap_hit      = 1'b0;
    quote_open   = qas_pkg::QUOTE_NONE;
    word_count   = 8'd0;
  endfunction

  // advance the line state by one accepted byte and queue its results
  task automatic split_byte(input logic [7:0] c);
    qas_pkg::result_t step_q[$];
    qas_pkg::quote_e  q;
    logic [7:0]       idx;
    logic             blank;
    if (c == qas_pkg::CHAR_NUL) begin
      if (in_word) begin
        step_q.push_back(make_result(qas_pkg::KIND_ARG_END, 8'd0, word_count - 8'd1));
      end
      step_q.push_back(make_result(qas_pkg::KIND_EOL, 8'd0, word_count));
      clear_line_state();
    end else if (!cap_hit) begin
      blank = is_blank(c);
      if (!in_word && !blank && word_count < arg_limit) begin
        in_word = 1'b1;
        word_count++;
      end
      if (in_word) begin
        idx = word_count - 8'd1;
        q   = quote_of(c);
        if (escape_armed) begin
          escape_armed = 1'b0;
          step_q.push_back(make_result(qas_pkg::KIND_BYTE, c, idx));
        end else if (c == qas_pkg::CHAR_BACKSLASH) begin
          escape_armed = 1'b1;
        end else if (quote_open != qas_pkg::QUOTE_NONE && q == quote_open) begin
          quote_open = qas_pkg::QUOTE_NONE;
        end else if (q != qas_pkg::QUOTE_NONE) begin
          // a different quote replaces the open one
          quote_open = q;
        end else if (quote_open != qas_pkg::QUOTE_NONE) begin
          step_q.push_back(make_result(qas_pkg::KIND_BYTE, c, idx));
        end else if (blank) begin
          in_word = 1'b0;
          step_q.push_back(make_result(qas_pkg::KIND_ARG_END, 8'd0, idx));
          if (word_count >= arg_limit) cap_hit = 1'b1;
        end else begin
          step_q.push_back(make_result(qas_pkg::KIND_BYTE, c, idx));
        end
      end
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) split_results_q.push_back(step_q[i]);
  endtask

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_byte(input logic [7:0] c);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      char_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    char_bus.valid     <= 1'b1;
    char_bus.char_code <= c;
    do @(posedge clk); while (char_bus.ready !== 1'b1);
    split_byte(c);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_bytes(input byte_q_t line_q);
    foreach (line_q[i]) send_byte(line_q[i]);
  endtask

  task automatic write_max_args(input logic [7:0] v);
    char_bus.valid <= 1'b0;
    while (split_results_q.size() != 0) @(negedge clk);
    // a byte with no result may still be in the pipeline
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_bus.valid    <= 1'b1;
    cfg_bus.max_args <= v;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    arg_limit = v;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic logic [7:0] blank_byte();
    int r;
    r = $urandom_range(0, 6);
    return (r >= 5) ? qas_pkg::CHAR_SPACE : 8'h09 + r[7:0];
  endfunction

  function automatic logic [7:0] quote_byte();
    case ($urandom_range(0, 2))
      0:       return qas_pkg::CHAR_SQUOTE;
      1:       return qas_pkg::CHAR_DQUOTE;
      default: return qas_pkg::CHAR_BQUOTE;
    endcase
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (is_blank(c) || quote_of(c) != qas_pkg::QUOTE_NONE ||
           c == qas_pkg::CHAR_BACKSLASH);
    return c;
  endfunction

  function automatic logic [7:0] any_byte();
    case ($urandom_range(0, 4))
      0:       return blank_byte();
      1:       return quote_byte();
      2:       return qas_pkg::CHAR_BACKSLASH;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic send_word();
    logic [7:0] qc;
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 5))
        0: begin
          send_byte(qas_pkg::CHAR_BACKSLASH);
          send_byte(any_byte());
        end
        1: begin
          qc = quote_byte();
          send_byte(qc);
          repeat ($urandom_range(0, 3)) send_byte(any_byte());
          if ($urandom_range(0, 4) != 0) send_byte(qc);
        end
        default: send_byte(plain_byte());
      endcase
    end
  endtask

  task automatic send_word_line();
    int n_words;
    n_words = $urandom_range(1, 7);
    for (int w = 0; w < n_words; w++) begin
      if ($urandom_range(0, 2) == 0) send_byte(blank_byte());
      send_word();
      // sometimes the line ends inside the last argument
      if (w < n_words - 1 || $urandom_range(0, 1) == 0) send_byte(blank_byte());
    end
    send_byte(qas_pkg::CHAR_NUL);
  endtask

  task automatic send_noise_line();
    repeat ($urandom_range(1, 12)) send_byte(any_byte());
    send_byte(qas_pkg::CHAR_NUL);
  endtask

  task automatic test_separators();
    send_bytes({qas_pkg::CHAR_TAB, 8'hFF, 8'h0B, 8'h01, qas_pkg::CHAR_SPACE,
                qas_pkg::CHAR_NUL});
  endtask

  task automatic test_quotes_and_escapes();
    send_bytes({qas_pkg::CHAR_SQUOTE, 8'h61, qas_pkg::CHAR_SPACE, qas_pkg::CHAR_DQUOTE,
                qas_pkg::CHAR_SPACE, qas_pkg::CHAR_DQUOTE, qas_pkg::CHAR_BACKSLASH,
                qas_pkg::CHAR_SQUOTE, qas_pkg::CHAR_NUL});
  endtask

  // empty quoted argument, open quote and pending escape at line end, lone zero
  task automatic test_line_end_cases();
    send_bytes({qas_pkg::CHAR_DQUOTE, qas_pkg::CHAR_DQUOTE, qas_pkg::CHAR_SPACE,
                qas_pkg::CHAR_BQUOTE, qas_pkg::CHAR_BACKSLASH, qas_pkg::CHAR_NUL,
                qas_pkg::CHAR_NUL});
  endtask

  task automatic test_arg_limit();
    write_max_args(8'd0);
    send_bytes({8'h61, qas_pkg::CHAR_NUL});
    write_max_args(8'd1);
    send_bytes({8'h61, qas_pkg::CHAR_SPACE, 8'h62, qas_pkg::CHAR_NUL});
  endtask

  task automatic test_limit_lowered_mid_line();
    write_max_args(8'd2);
    send_bytes({8'h61, qas_pkg::CHAR_SPACE, 8'h62});
    write_max_args(8'd1);
    send_bytes({8'h63, qas_pkg::CHAR_SPACE, 8'h64, qas_pkg::CHAR_NUL});
  endtask

  task automatic test_random_lines();
    int target;
    int lines;
    target = bytes_sent + RANDOM_ITEMS;
    lines  = 0;
    while (bytes_sent < target) begin
      if (lines == 0) begin
        write_max_args(8'd255);
      end else if (lines % 6 == 0) begin
        case ($urandom_range(0, 7))
          0:       write_max_args(8'd0);
          1:       write_max_args(8'd255);
          2:       write_max_args(qas_pkg::MAX_ARGS_RESET);
          default: write_max_args(8'($urandom_range(1, 6)));
        endcase
      end
      no_gaps = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 4) == 0) send_noise_line();
      else send_word_line();
      lines++;
    end
    no_gaps = 1'b0;
  endtask

  always @(posedge clk) begin : result_check
    qas_pkg::result_t got;
    qas_pkg::result_t want;
    if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
      got = {res_bus.kind, res_bus.value, res_bus.arg_index, res_bus.last};
      if (split_results_q.size() == 0) begin
        fail_count++;
        $display("%0t unexpected result: kind %0d value %h index %0d last %0b",
                 $time, got.kind, got.value, got.arg_index, got.last);
      end else begin
        want = split_results_q.pop_front();
        if (got.kind !== want.kind || got.value !== want.value ||
            got.arg_index !== want.arg_index || got.last !== want.last) begin
          fail_count++;
          $display(
            "%0t mismatch kind/value/index/last expected %0d/%h/%0d/%0b got %0d/%h/%0d/%0b",
            $time, want.kind, want.value, want.arg_index, want.last,
            got.kind, got.value, got.arg_index, got.last);
        end
      end
      res_stall = no_gaps ? 0 : $urandom_range(0, 3);
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
    end else if (no_gaps || res_stall == 0) begin
      res_bus.ready <= 1'b1;
    end else begin
      res_bus.ready <= 1'b0;
      res_stall--;
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((char_bus.valid === 1'b1 && char_bus.ready === 1'b1) ||
          (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) ||
          (cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.max_args   = 8'd0;
    char_bus.valid     = 1'b0;
    char_bus.char_code = 8'd0;
    res_bus.ready      = 1'b0;
    fail_count         = 0;
    bytes_sent         = 0;
    no_gaps            = 1'b0;
    res_stall          = 0;
    arg_limit          = qas_pkg::MAX_ARGS_RESET;
    clear_line_state();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_separators();
    test_quotes_and_escapes();
    test_line_end_cases();
    test_arg_limit();
    test_limit_lowered_mid_line();
    test_random_lines();

    char_bus.valid <= 1'b0;
    while (split_results_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
src/qas_pkg.sv
src/qas_char_if.sv
src/qas_result_if.sv
src/qas_cfg_if.sv
src/quoted_argument_splitter_top.sv
src/qas_checker.sv
verif/tb_quoted_argument_splitter_top.sv
